// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Default sizing
  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // Operation codes; unused codes act as a query
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REAR  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_REAR   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_QUERY      = 3'd5
  } op_t;

  // Input transaction
  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    logic                      overflow;
  } out_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words in a circular RAM with head/tail pointers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per transaction (push rear/front, pop rear/front,
//           clear, query) with the word to push.
//   out_* : exactly one result per operation: front and rear words after
//           the operation (all ones when empty), count, empty and overflow.
//   The result is valid in the cycle after the operation is accepted.
//   Throughput is one operation per cycle while the receiver takes each
//   result, set by the single RAM write port and the two registered RAM
//   read ports that fetch the new front and rear in the accept cycle; a
//   word written in that same cycle is forwarded to the read registers.
//   A push onto a full queue changes nothing and sets overflow; a pop on
//   an empty queue changes nothing.
//   Reset clears the pointers, the count and the result valid; RAM
//   contents stay undefined and are only shown after being written.
//   When the receiver stalls, the result holds and in_ready stays low
//   until the result is taken; a new operation may be accepted in the
//   same cycle the pending result leaves.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int CAPACITY  = deq_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  deq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output deq_pkg::out_t out_data
);

  localparam int PTR_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

  typedef logic signed [WORD_BITS-1:0] word_t;

  // Entry RAM
  word_t mem [CAPACITY];

  // Control state
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic             overflow_r, overflow_nxt;

  // Read data registers
  word_t rd_front_r;
  word_t rd_rear_r;

  // Write port and read addresses
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  word_t            wr_data;
  logic [PTR_W-1:0] front_addr;
  logic [PTR_W-1:0] rear_addr;

  logic in_fire;
  logic full;
  logic empty;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
    next_slot = (i == LAST_SLOT) ? '0 : i + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] i);
    prev_slot = (i == '0) ? LAST_SLOT : i - PTR_W'(1);
  endfunction

  // Handshake: output register frees when taken
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign wr_data  = WORD_BITS'(in_data.value);

  // Pointer, count and write-port update
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    overflow_nxt = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = tail_r;
    case (in_data.operation)
      deq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          overflow_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = tail_r;
          tail_nxt  = next_slot(tail_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          overflow_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          head_nxt  = prev_slot(head_r);
          wr_addr   = prev_slot(head_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      deq_pkg::OP_POP_REAR: begin
        if (!empty) begin
          tail_nxt  = prev_slot(tail_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (!empty) begin
          head_nxt  = next_slot(head_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      deq_pkg::OP_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    front_addr = head_nxt;
    rear_addr  = prev_slot(tail_nxt);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      overflow_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        head_r     <= head_nxt;
        tail_r     <= tail_nxt;
        count_r    <= count_nxt;
        overflow_r <= overflow_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // RAM write
  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // RAM reads with forwarding of the word written this cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_front_r <= (wr_en && (wr_addr == front_addr)) ? wr_data : mem[front_addr];
      rd_rear_r  <= (wr_en && (wr_addr == rear_addr))  ? wr_data : mem[rear_addr];
    end
  end

  // Result formatting
  always_comb begin
    out_data.count       = deq_pkg::COUNT_W'(count_r);
    out_data.is_empty    = (count_r == '0);
    out_data.overflow    = overflow_r;
    if (count_r == '0) begin
      out_data.front_value = '1;
      out_data.rear_value  = '1;
    end else begin
      out_data.front_value = deq_pkg::VALUE_W'(rd_front_r);
      out_data.rear_value  = deq_pkg::VALUE_W'(rd_rear_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule
